// ===== design/fhi_pkg.sv =====
`default_nettype none
package fhi_pkg;

    localparam int WINDOW_SIZE_DEF      = 32768;
    localparam int BYTES_PER_RESULT_DEF = 8;

    localparam logic [1:0] STAT_DATA  = 2'd0;
    localparam logic [1:0] STAT_DONE  = 2'd1;
    localparam logic [1:0] STAT_ERROR = 2'd2;
    localparam logic [1:0] STAT_TRUNC = 2'd3;

    typedef enum logic [10:0] {
        PH_HEADER     = 11'b000_0000_0001,
        PH_LITLEN     = 11'b000_0000_0010,
        PH_LEN_EXTRA  = 11'b000_0000_0100,
        PH_DIST_CODE  = 11'b000_0000_1000,
        PH_DIST_EXTRA = 11'b000_0001_0000,
        PH_ST_LEN_LO  = 11'b000_0010_0000,
        PH_ST_LEN_HI  = 11'b000_0100_0000,
        PH_ST_NLEN_LO = 11'b000_1000_0000,
        PH_ST_NLEN_HI = 11'b001_0000_0000,
        PH_ST_COPY    = 11'b010_0000_0000,
        PH_HALT       = 11'b100_0000_0000
    } phase_t;

    typedef enum logic [6:0] {
        C_IDLE    = 7'b000_0001,
        C_STEP    = 7'b000_0010,
        C_COPY_RD = 7'b000_0100,
        C_COPY_WR = 7'b000_1000,
        C_ENDBLK  = 7'b001_0000,
        C_CLOSE   = 7'b010_0000,
        C_FLUSH   = 7'b100_0000
    } ctrl_t;

    function automatic logic [8:0] len_lookup(input logic [4:0] idx);
        logic [8:0] r;
        case (idx)
            5'd0: r = 9'd3;     5'd1: r = 9'd4;     5'd2: r = 9'd5;     5'd3: r = 9'd6;
            5'd4: r = 9'd7;     5'd5: r = 9'd8;     5'd6: r = 9'd9;     5'd7: r = 9'd10;
            5'd8: r = 9'd11;    5'd9: r = 9'd13;    5'd10: r = 9'd15;   5'd11: r = 9'd17;
            5'd12: r = 9'd19;   5'd13: r = 9'd23;   5'd14: r = 9'd27;   5'd15: r = 9'd31;
            5'd16: r = 9'd35;   5'd17: r = 9'd43;   5'd18: r = 9'd51;   5'd19: r = 9'd59;
            5'd20: r = 9'd67;   5'd21: r = 9'd83;   5'd22: r = 9'd99;   5'd23: r = 9'd115;
            5'd24: r = 9'd131;  5'd25: r = 9'd163;  5'd26: r = 9'd195;  5'd27: r = 9'd227;
            5'd28: r = 9'd258;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] len_extra(input logic [4:0] idx);
        logic [3:0] r;
        if (idx < 5'd8 || idx == 5'd28)
        begin
            r = 4'd0;
        end
        else
        begin
            r = 4'(((idx - 5'd8) >> 2) + 5'd1);
        end
        return r;
    endfunction

    function automatic logic [15:0] dist_lookup(input logic [4:0] idx);
        logic [15:0] r;
        case (idx)
            5'd0: r = 16'd1;      5'd1: r = 16'd2;      5'd2: r = 16'd3;      5'd3: r = 16'd4;
            5'd4: r = 16'd5;      5'd5: r = 16'd7;      5'd6: r = 16'd9;      5'd7: r = 16'd13;
            5'd8: r = 16'd17;     5'd9: r = 16'd25;     5'd10: r = 16'd33;    5'd11: r = 16'd49;
            5'd12: r = 16'd65;    5'd13: r = 16'd97;    5'd14: r = 16'd129;   5'd15: r = 16'd193;
            5'd16: r = 16'd257;   5'd17: r = 16'd385;   5'd18: r = 16'd513;   5'd19: r = 16'd769;
            5'd20: r = 16'd1025;  5'd21: r = 16'd1537;  5'd22: r = 16'd2049;  5'd23: r = 16'd3073;
            5'd24: r = 16'd4097;  5'd25: r = 16'd6145;  5'd26: r = 16'd8193;  5'd27: r = 16'd12289;
            5'd28: r = 16'd16385; 5'd29: r = 16'd24577;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] dist_extra(input logic [4:0] idx);
        logic [3:0] r;
        if (idx < 5'd4)
        begin
            r = 4'd0;
        end
        else
        begin
            r = 4'((idx >> 1) - 5'd1);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/fixed_huffman_inflate.sv =====
// Fixed-Huffman DEFLATE decoder.
// Input stream: one compressed byte per transfer on s_tdata, bits used LSB first; s_tlast
// marks the final byte of the stream. Output stream: m_tdata carries up to eight decoded
// bytes and their count, m_tuser the status (data, done, error, truncated), m_tlast marks
// the last result caused by one input byte.
// Each input byte is decoded one header or code bit per step, or in one step for a byte
// of a stored block; each byte of a match copy is one read and then one write of the
// history RAM. Around that the byte is taken in the idle state, closed, and its last
// result released in the flush state, with an end-of-block step before the close when it
// is the last data byte of a stored block. The next byte is taken only once the current one is finished.
// A result waits in a holding stage until the next result or the end of its input byte
// tells whether it is the last one; a stalled output stalls decoding only when both the
// output register and the holding stage are full.
// Reset clears all control state; the history RAM is not cleared, since distances are
// checked against the bytes written. After a closing result (done, error, truncated) the
// block drops all further input until reset.
`default_nettype none
module fixed_huffman_inflate #(
    parameter int WINDOW_SIZE      = fhi_pkg::WINDOW_SIZE_DEF,
    parameter int BYTES_PER_RESULT = fhi_pkg::BYTES_PER_RESULT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // in_byte
    input  wire logic        s_tlast,   // in_last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [71:0] m_tdata,   // out_bytes[63:0], byte_count[67:64], zero fill
    output logic      [1:0]  m_tuser,   // status
    output logic             m_tlast    // run_last
);

    localparam int AW  = $clog2(WINDOW_SIZE);
    localparam int WCW = $clog2(WINDOW_SIZE + 1);

    fhi_pkg::ctrl_t  ctrl_reg, ctrl_next;
    fhi_pkg::phase_t phase_reg, phase_next;
    logic [7:0]     byte_reg, byte_next;
    logic           last_reg, last_next;
    logic [2:0]     bit_idx_reg, bit_idx_next;
    logic [12:0]    buf_reg, buf_next;
    logic [3:0]     cnt_reg, cnt_next;
    logic [3:0]     extra_reg, extra_next;
    logic           final_reg, final_next;
    logic [8:0]     len_reg, len_next;
    logic [15:0]    dist_reg, dist_next;
    logic [15:0]    rem_reg, rem_next;
    logic [AW-1:0]  wp_reg, wp_next;
    logic [WCW-1:0] wcnt_reg, wcnt_next;
    logic [63:0]    pack_reg, pack_next;
    logic [3:0]     pcnt_reg, pcnt_next;
    logic           pend_valid_reg, pend_valid_next;
    logic [63:0]    pend_bytes_reg, pend_bytes_next;
    logic [3:0]     pend_cnt_reg, pend_cnt_next;
    logic [1:0]     pend_stat_reg, pend_stat_next;
    logic           out_valid_reg, out_valid_next;
    logic [63:0]    out_bytes_reg, out_bytes_next;
    logic [3:0]     out_cnt_reg, out_cnt_next;
    logic [1:0]     out_stat_reg, out_stat_next;
    logic           out_last_reg, out_last_next;

    logic           ram_we;
    logic [7:0]     ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic [7:0]     ram_rdata;

    logic           out_free;
    logic           step_ok;
    logic           emit;
    logic [7:0]     emit_b;
    logic           push;
    logic [1:0]     push_st;
    logic           flush;
    logic           copy_go;
    logic           b;
    logic [12:0]    nbuf_or;
    logic [12:0]    nbuf_sh;
    logic [3:0]     ncnt;
    logic [4:0]     sidx;
    logic [16:0]    wp_ext;
    logic [16:0]    rd_idx;
    logic [3:0]     pcnt_inc;

    fhi_ram #(
        .WIDTH(8),
        .DEPTH(WINDOW_SIZE)
    ) u_hist (
        .clk  (clk),
        .we   (ram_we),
        .waddr(wp_reg),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign step_ok  = !pend_valid_reg || out_free;
    assign s_tready = (ctrl_reg == fhi_pkg::C_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_cnt_reg, out_bytes_reg};
    assign m_tuser  = out_stat_reg;
    assign m_tlast  = out_last_reg;

    assign wp_ext    = 17'(wp_reg);
    assign rd_idx    = (wp_ext >= {1'b0, dist_reg}) ? wp_ext - {1'b0, dist_reg}
                                                    : wp_ext + 17'(WINDOW_SIZE) - {1'b0, dist_reg};
    assign ram_raddr = rd_idx[AW-1:0];

    assign b       = byte_reg[bit_idx_reg];
    assign nbuf_or = buf_reg | (13'(b) << cnt_reg);
    assign nbuf_sh = {buf_reg[11:0], b};
    assign ncnt    = cnt_reg + 4'd1;

    always_comb
    begin
        ctrl_next       = ctrl_reg;
        phase_next      = phase_reg;
        byte_next       = byte_reg;
        last_next       = last_reg;
        bit_idx_next    = bit_idx_reg;
        buf_next        = buf_reg;
        cnt_next        = cnt_reg;
        extra_next      = extra_reg;
        final_next      = final_reg;
        len_next        = len_reg;
        dist_next       = dist_reg;
        rem_next        = rem_reg;
        wp_next         = wp_reg;
        wcnt_next       = wcnt_reg;
        pack_next       = pack_reg;
        pcnt_next       = pcnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_bytes_next = pend_bytes_reg;
        pend_cnt_next   = pend_cnt_reg;
        pend_stat_next  = pend_stat_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_bytes_next  = out_bytes_reg;
        out_cnt_next    = out_cnt_reg;
        out_stat_next   = out_stat_reg;
        out_last_next   = out_last_reg;
        emit            = 1'b0;
        emit_b          = 8'd0;
        push            = 1'b0;
        push_st         = fhi_pkg::STAT_DATA;
        flush           = 1'b0;
        copy_go         = 1'b0;
        sidx            = 5'd0;
        ram_we          = 1'b0;
        ram_wdata       = 8'd0;
        pcnt_inc        = 4'd0;

        case (ctrl_reg)
            fhi_pkg::C_IDLE:
            begin
                if (s_tvalid)
                begin
                    byte_next    = s_tdata;
                    last_next    = s_tlast;
                    bit_idx_next = 3'd0;
                    ctrl_next    = fhi_pkg::C_STEP;
                end
            end
            fhi_pkg::C_STEP:
            begin
                if (step_ok)
                begin
                    case (phase_reg)
                        fhi_pkg::PH_HEADER:
                        begin
                            buf_next = nbuf_or;
                            cnt_next = ncnt;
                            if (ncnt == 4'd3)
                            begin
                                final_next = nbuf_or[0];
                                buf_next   = 13'd0;
                                cnt_next   = 4'd0;
                                if (nbuf_or[2:1] == 2'd1)
                                begin
                                    phase_next = fhi_pkg::PH_LITLEN;
                                end
                                else if (nbuf_or[2:1] == 2'd0)
                                begin
                                    phase_next = fhi_pkg::PH_ST_LEN_LO;
                                end
                                else
                                begin
                                    push       = 1'b1;
                                    push_st    = fhi_pkg::STAT_ERROR;
                                    phase_next = fhi_pkg::PH_HALT;
                                end
                            end
                        end
                        fhi_pkg::PH_LITLEN:
                        begin
                            buf_next = nbuf_sh;
                            cnt_next = ncnt;
                            if (ncnt == 4'd7 && nbuf_sh <= 13'h17)
                            begin
                                buf_next = 13'd0;
                                cnt_next = 4'd0;
                                if (nbuf_sh == 13'd0)
                                begin
                                    if (final_reg)
                                    begin
                                        push       = 1'b1;
                                        push_st    = fhi_pkg::STAT_DONE;
                                        phase_next = fhi_pkg::PH_HALT;
                                    end
                                    else
                                    begin
                                        phase_next = fhi_pkg::PH_HEADER;
                                    end
                                end
                                else
                                begin
                                    sidx       = nbuf_sh[4:0] - 5'd1;
                                    len_next   = fhi_pkg::len_lookup(sidx);
                                    extra_next = fhi_pkg::len_extra(sidx);
                                    phase_next = (fhi_pkg::len_extra(sidx) != 4'd0)
                                                 ? fhi_pkg::PH_LEN_EXTRA : fhi_pkg::PH_DIST_CODE;
                                end
                            end
                            else if (ncnt == 4'd8 && nbuf_sh >= 13'h30 && nbuf_sh <= 13'hBF)
                            begin
                                buf_next = 13'd0;
                                cnt_next = 4'd0;
                                emit     = 1'b1;
                                emit_b   = 8'(nbuf_sh - 13'h30);
                            end
                            else if (ncnt == 4'd8 && nbuf_sh >= 13'hC0 && nbuf_sh <= 13'hC7)
                            begin
                                buf_next = 13'd0;
                                cnt_next = 4'd0;
                                if (nbuf_sh[2:0] <= 3'd5)
                                begin
                                    sidx       = 5'd23 + 5'(nbuf_sh[2:0]);
                                    len_next   = fhi_pkg::len_lookup(sidx);
                                    extra_next = fhi_pkg::len_extra(sidx);
                                    phase_next = (fhi_pkg::len_extra(sidx) != 4'd0)
                                                 ? fhi_pkg::PH_LEN_EXTRA : fhi_pkg::PH_DIST_CODE;
                                end
                                else
                                begin
                                    push       = 1'b1;
                                    push_st    = fhi_pkg::STAT_ERROR;
                                    phase_next = fhi_pkg::PH_HALT;
                                end
                            end
                            else if (ncnt >= 4'd9)
                            begin
                                buf_next = 13'd0;
                                cnt_next = 4'd0;
                                if (nbuf_sh >= 13'h190 && nbuf_sh <= 13'h1FF)
                                begin
                                    emit   = 1'b1;
                                    emit_b = nbuf_sh[7:0];
                                end
                                else
                                begin
                                    push       = 1'b1;
                                    push_st    = fhi_pkg::STAT_ERROR;
                                    phase_next = fhi_pkg::PH_HALT;
                                end
                            end
                        end
                        fhi_pkg::PH_LEN_EXTRA:
                        begin
                            buf_next = nbuf_or;
                            cnt_next = ncnt;
                            if (ncnt >= extra_reg)
                            begin
                                len_next   = len_reg + 9'(nbuf_or[4:0]);
                                buf_next   = 13'd0;
                                cnt_next   = 4'd0;
                                phase_next = fhi_pkg::PH_DIST_CODE;
                            end
                        end
                        fhi_pkg::PH_DIST_CODE:
                        begin
                            buf_next = nbuf_sh;
                            cnt_next = ncnt;
                            if (ncnt == 4'd5)
                            begin
                                buf_next = 13'd0;
                                cnt_next = 4'd0;
                                if (nbuf_sh[4:0] > 5'd29)
                                begin
                                    push       = 1'b1;
                                    push_st    = fhi_pkg::STAT_ERROR;
                                    phase_next = fhi_pkg::PH_HALT;
                                end
                                else
                                begin
                                    dist_next  = fhi_pkg::dist_lookup(nbuf_sh[4:0]);
                                    extra_next = fhi_pkg::dist_extra(nbuf_sh[4:0]);
                                    if (fhi_pkg::dist_extra(nbuf_sh[4:0]) != 4'd0)
                                    begin
                                        phase_next = fhi_pkg::PH_DIST_EXTRA;
                                    end
                                    else
                                    begin
                                        copy_go = 1'b1;
                                    end
                                end
                            end
                        end
                        fhi_pkg::PH_DIST_EXTRA:
                        begin
                            buf_next = nbuf_or;
                            cnt_next = ncnt;
                            if (ncnt >= extra_reg)
                            begin
                                dist_next = dist_reg + 16'(nbuf_or);
                                buf_next  = 13'd0;
                                cnt_next  = 4'd0;
                                copy_go   = 1'b1;
                            end
                        end
                        fhi_pkg::PH_ST_LEN_LO:
                        begin
                            rem_next   = {8'd0, byte_reg};
                            phase_next = fhi_pkg::PH_ST_LEN_HI;
                        end
                        fhi_pkg::PH_ST_LEN_HI:
                        begin
                            rem_next   = {byte_reg, rem_reg[7:0]};
                            phase_next = fhi_pkg::PH_ST_NLEN_LO;
                        end
                        fhi_pkg::PH_ST_NLEN_LO:
                        begin
                            phase_next = fhi_pkg::PH_ST_NLEN_HI;
                        end
                        fhi_pkg::PH_ST_NLEN_HI:
                        begin
                            if (rem_reg == 16'd0)
                            begin
                                buf_next = 13'd0;
                                cnt_next = 4'd0;
                                if (final_reg)
                                begin
                                    push       = 1'b1;
                                    push_st    = fhi_pkg::STAT_DONE;
                                    phase_next = fhi_pkg::PH_HALT;
                                end
                                else
                                begin
                                    phase_next = fhi_pkg::PH_HEADER;
                                end
                            end
                            else
                            begin
                                phase_next = fhi_pkg::PH_ST_COPY;
                            end
                        end
                        fhi_pkg::PH_ST_COPY:
                        begin
                            emit     = 1'b1;
                            emit_b   = byte_reg;
                            rem_next = rem_reg - 16'd1;
                        end
                        default:
                        begin
                        end
                    endcase

                    if (copy_go)
                    begin
                        phase_next = fhi_pkg::PH_LITLEN;
                        if (dist_next == 16'd0 || {1'b0, dist_next} > 17'(wcnt_reg))
                        begin
                            push       = 1'b1;
                            push_st    = fhi_pkg::STAT_ERROR;
                            phase_next = fhi_pkg::PH_HALT;
                            ctrl_next  = fhi_pkg::C_CLOSE;
                        end
                        else
                        begin
                            ctrl_next = fhi_pkg::C_COPY_RD;
                        end
                    end
                    else if (phase_reg == fhi_pkg::PH_ST_COPY && rem_reg == 16'd1)
                    begin
                        ctrl_next = fhi_pkg::C_ENDBLK;
                    end
                    else if (phase_reg == fhi_pkg::PH_ST_LEN_LO
                             || phase_reg == fhi_pkg::PH_ST_LEN_HI
                             || phase_reg == fhi_pkg::PH_ST_NLEN_LO
                             || phase_reg == fhi_pkg::PH_ST_NLEN_HI
                             || phase_reg == fhi_pkg::PH_ST_COPY
                             || phase_next == fhi_pkg::PH_ST_LEN_LO
                             || phase_next == fhi_pkg::PH_HALT
                             || bit_idx_reg == 3'd7)
                    begin
                        ctrl_next = fhi_pkg::C_CLOSE;
                    end
                    else
                    begin
                        bit_idx_next = bit_idx_reg + 3'd1;
                    end
                end
            end
            fhi_pkg::C_COPY_RD:
            begin
                ctrl_next = fhi_pkg::C_COPY_WR;
            end
            fhi_pkg::C_COPY_WR:
            begin
                if (step_ok)
                begin
                    emit     = 1'b1;
                    emit_b   = ram_rdata;
                    len_next = len_reg - 9'd1;
                    if (len_reg == 9'd1)
                    begin
                        if (bit_idx_reg == 3'd7)
                        begin
                            ctrl_next = fhi_pkg::C_CLOSE;
                        end
                        else
                        begin
                            bit_idx_next = bit_idx_reg + 3'd1;
                            ctrl_next    = fhi_pkg::C_STEP;
                        end
                    end
                    else
                    begin
                        ctrl_next = fhi_pkg::C_COPY_RD;
                    end
                end
            end
            fhi_pkg::C_ENDBLK:
            begin
                if (step_ok)
                begin
                    buf_next = 13'd0;
                    cnt_next = 4'd0;
                    if (final_reg)
                    begin
                        push       = 1'b1;
                        push_st    = fhi_pkg::STAT_DONE;
                        phase_next = fhi_pkg::PH_HALT;
                    end
                    else
                    begin
                        phase_next = fhi_pkg::PH_HEADER;
                    end
                    ctrl_next = fhi_pkg::C_CLOSE;
                end
            end
            fhi_pkg::C_CLOSE:
            begin
                if (step_ok)
                begin
                    if (last_reg && phase_reg != fhi_pkg::PH_HALT)
                    begin
                        push       = 1'b1;
                        push_st    = fhi_pkg::STAT_TRUNC;
                        phase_next = fhi_pkg::PH_HALT;
                    end
                    ctrl_next = fhi_pkg::C_FLUSH;
                end
            end
            fhi_pkg::C_FLUSH:
            begin
                if (step_ok)
                begin
                    flush     = pend_valid_reg;
                    ctrl_next = fhi_pkg::C_IDLE;
                end
            end
            default:
            begin
                ctrl_next = fhi_pkg::C_IDLE;
            end
        endcase

        if (emit)
        begin
            ram_we    = 1'b1;
            ram_wdata = emit_b;
            wp_next   = (wp_reg == AW'(WINDOW_SIZE - 1)) ? '0 : wp_reg + AW'(1);
            if (wcnt_reg != WCW'(WINDOW_SIZE))
            begin
                wcnt_next = wcnt_reg + WCW'(1);
            end
            pcnt_inc  = pcnt_reg + 4'd1;
            pack_next = pack_reg | ({56'd0, emit_b} << {pcnt_reg[2:0], 3'b000});
            pcnt_next = pcnt_inc;
            if (pcnt_inc >= 4'(BYTES_PER_RESULT))
            begin
                push    = 1'b1;
                push_st = fhi_pkg::STAT_DATA;
            end
        end

        if (push)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_bytes_next = pend_bytes_reg;
                out_cnt_next   = pend_cnt_reg;
                out_stat_next  = pend_stat_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_bytes_next = pack_next;
            pend_cnt_next   = pcnt_next;
            pend_stat_next  = push_st;
            pack_next       = 64'd0;
            pcnt_next       = 4'd0;
        end

        if (flush)
        begin
            out_valid_next  = 1'b1;
            out_bytes_next  = pend_bytes_reg;
            out_cnt_next    = pend_cnt_reg;
            out_stat_next   = pend_stat_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg       <= fhi_pkg::C_IDLE;
            phase_reg      <= fhi_pkg::PH_HEADER;
            bit_idx_reg    <= 3'd0;
            buf_reg        <= 13'd0;
            cnt_reg        <= 4'd0;
            extra_reg      <= 4'd0;
            final_reg      <= 1'b0;
            len_reg        <= 9'd0;
            dist_reg       <= 16'd0;
            rem_reg        <= 16'd0;
            wp_reg         <= '0;
            wcnt_reg       <= '0;
            pack_reg       <= 64'd0;
            pcnt_reg       <= 4'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            ctrl_reg       <= ctrl_next;
            phase_reg      <= phase_next;
            bit_idx_reg    <= bit_idx_next;
            buf_reg        <= buf_next;
            cnt_reg        <= cnt_next;
            extra_reg      <= extra_next;
            final_reg      <= final_next;
            len_reg        <= len_next;
            dist_reg       <= dist_next;
            rem_reg        <= rem_next;
            wp_reg         <= wp_next;
            wcnt_reg       <= wcnt_next;
            pack_reg       <= pack_next;
            pcnt_reg       <= pcnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg       <= byte_next;
        last_reg       <= last_next;
        pend_bytes_reg <= pend_bytes_next;
        pend_cnt_reg   <= pend_cnt_next;
        pend_stat_reg  <= pend_stat_next;
        out_bytes_reg  <= out_bytes_next;
        out_cnt_reg    <= out_cnt_next;
        out_stat_reg   <= out_stat_next;
        out_last_reg   <= out_last_next;
    end

`ifndef SYNTHESIS
    a_pack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pcnt_reg < 4'(BYTES_PER_RESULT))
        else $error("pack count reached a full result without release");

    a_wcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wcnt_reg <= WCW'(WINDOW_SIZE))
        else $error("written count above window size");

    a_copy_len: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_reg == fhi_pkg::C_COPY_RD) |-> (len_reg != 9'd0
            && dist_reg != 16'd0 && {1'b0, dist_reg} <= 17'(wcnt_reg)))
        else $error("match copy with empty length or bad distance");

    a_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (ctrl_reg == fhi_pkg::C_STEP || ctrl_reg == fhi_pkg::C_COPY_WR))
        else $error("history write outside a decode step");

    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == fhi_pkg::PH_HALT) |=> (phase_reg == fhi_pkg::PH_HALT && !ram_we))
        else $error("decoder left halt");
`endif

endmodule
`default_nettype wire

// ===== design/fhi_ram.sv =====
`default_nettype none
module fhi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire
